// ===== rtl/per_source_burst_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-source burst detector
// Shorthand for clocked implication checks; the module must have clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_BURST_DETECTOR_MACROS_SVH
`define PER_SOURCE_BURST_DETECTOR_MACROS_SVH

// same-cycle implication
`define PSBD_ASSERT_NOW(lbl, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define PSBD_ASSERT_NEXT(lbl, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/psbd_pkg.sv =====
// ----------------------------------------------------------------------------
// psbd_pkg
// Shared types and constants of the per-source burst detector.
// ----------------------------------------------------------------------------
package psbd_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int WINDOW_MAX_DEF    = 8;

	localparam int ADDR_W = 32;
	localparam int TIME_W = 32;
	localparam int SPAN_W = 16;
	localparam int WCNT_W = 4;

	localparam logic [WCNT_W-1:0] WINDOW_COUNT_RST = 4'd5;
	localparam logic [SPAN_W-1:0] TIME_SPAN_RST    = 16'd2;

	typedef enum logic [0:0] {
		REG_WINDOW_COUNT = 1'b0,
		REG_TIME_SPAN    = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		FUNC_RECORD = 1'b0,
		FUNC_CLEAR  = 1'b1
	} func_t;

	// transaction travelling down the cell chain
	typedef struct packed {
		logic              valid;
		func_t             func;
		logic [ADDR_W-1:0] src;
		logic [TIME_W-1:0] tstamp;
		logic              done;   // hit or claimed an entry
		logic              burst;  // burst flagged on this transaction
	} token_t;

endpackage

// ===== rtl/per_source_burst_detector.sv =====
// ----------------------------------------------------------------------------
// per_source_burst_detector
// Per-source request burst detector built as a chain of table-entry cells.
// ----------------------------------------------------------------------------
// Each input transaction is registered in every cell in turn before reaching m_tdata.
// Throughput: one transaction per cycle unless the output stalls; each transaction
//   walks one cell per cycle, so the chain length sets the latency, not the rate.
// A stalled output freezes the whole chain and deasserts s_tready.
// Reset: window_count = 5, time_span = 2, every entry free, chain empty.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "per_source_burst_detector_macros.svh"

module per_source_burst_detector #(
	parameter int TABLE_ENTRIES = psbd_pkg::TABLE_ENTRIES_DEF,
	parameter int WINDOW_MAX    = psbd_pkg::WINDOW_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] source_addr, [63:32] request_time
	input  logic [0:0]  s_tuser,   // [0] func (0 record, 1 clear)

	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] source_echo, [32] burst_found,
	                               // [33] untracked, [39:34] zero

	// configuration writes
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int HIST_DEPTH = WINDOW_MAX - 1;
	localparam int SEEN_W     = $clog2(WINDOW_MAX);
	localparam int HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

	localparam logic [4:0] WMAX_EXT = 5'(WINDOW_MAX);

	logic [psbd_pkg::WCNT_W-1:0] wcnt_q;
	logic [psbd_pkg::SPAN_W-1:0] span_q;

	logic [4:0]          wc_ext;
	logic [SEEN_W-1:0]   thr;
	logic [HIDX_W-1:0]   hidx;
	logic                adv;

	psbd_pkg::token_t    tok [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] used_vec;
	psbd_pkg::token_t    tail;
	logic                untr;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= psbd_pkg::WINDOW_COUNT_RST;
			span_q <= psbd_pkg::TIME_SPAN_RST;
		end else if (cfg_we) begin
			case (psbd_pkg::reg_idx_t'(cfg_index))
				psbd_pkg::REG_WINDOW_COUNT: wcnt_q <= cfg_data[psbd_pkg::WCNT_W-1:0];
				psbd_pkg::REG_TIME_SPAN:    span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp window_count into [2, WINDOW_MAX]; cells need count-1 and count-2
	always_comb begin
		wc_ext = {1'b0, wcnt_q};
		if (wc_ext < 5'd2) begin
			thr = SEEN_W'(1);
		end else if (wc_ext > WMAX_EXT) begin
			thr = SEEN_W'(WINDOW_MAX - 1);
		end else begin
			thr = SEEN_W'(wc_ext - 5'd1);
		end
		hidx = HIDX_W'(thr - 1'b1);
	end

	// ------------------------------------------------------------ chain
	// the whole chain moves together; the last cell's token is the output reg
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		tok[0]        = '0;
		tok[0].valid  = s_tvalid;
		tok[0].func   = psbd_pkg::func_t'(s_tuser[0]);
		tok[0].src    = s_tdata[31:0];
		tok[0].tstamp = s_tdata[63:32];
	end

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		psbd_cell #(
			.WINDOW_MAX (WINDOW_MAX),
			.HIST_DEPTH (HIST_DEPTH),
			.SEEN_W     (SEEN_W),
			.HIDX_W     (HIDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.thr      (thr),
			.hidx     (hidx),
			.span_lim (span_q),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1]),
			.used     (used_vec[g])
		);
	end

	// ------------------------------------------------------------ output
	assign tail     = tok[TABLE_ENTRIES];
	assign m_tvalid = tail.valid;
	// a record that neither matched nor claimed found the table full
	assign untr     = (tail.func == psbd_pkg::FUNC_RECORD) && !tail.done;

	always_comb begin
		m_tdata = '0;
		if (tail.func == psbd_pkg::FUNC_RECORD) begin
			m_tdata[31:0] = tail.src;
			m_tdata[32]   = tail.burst;
			m_tdata[33]   = untr;
		end
	end

	// ------------------------------------------------------------ checks
	`PSBD_ASSERT_NOW(a_untracked_no_burst, m_tvalid && m_tdata[33], !m_tdata[32])
	`PSBD_ASSERT_NOW(a_clear_zero, m_tvalid && (tail.func == psbd_pkg::FUNC_CLEAR), m_tdata == '0)
	`PSBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`PSBD_ASSERT_NEXT(a_clear_empties, adv && tok[0].valid && (tok[0].func == psbd_pkg::FUNC_CLEAR), !used_vec[0])

endmodule

// ===== rtl/psbd_cell.sv =====
// ----------------------------------------------------------------------------
// psbd_cell
// One table entry: source tag, recent request times, count and flag.
// Processes the passing transaction and hands it to the next cell.
// ----------------------------------------------------------------------------
module psbd_cell #(
	parameter int WINDOW_MAX = psbd_pkg::WINDOW_MAX_DEF,
	parameter int HIST_DEPTH = WINDOW_MAX - 1,
	parameter int SEEN_W     = $clog2(WINDOW_MAX),
	parameter int HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [SEEN_W-1:0]         thr,      // window_count - 1
	input  logic [HIDX_W-1:0]         hidx,     // window_count - 2
	input  logic [psbd_pkg::SPAN_W-1:0] span_lim,
	input  psbd_pkg::token_t          tok_in,
	output psbd_pkg::token_t          tok_out,
	output logic                      used
);

	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(HIST_DEPTH);

	logic                          used_q;
	logic [psbd_pkg::ADDR_W-1:0]   src_q;
	logic [psbd_pkg::TIME_W-1:0]   hist_q [HIST_DEPTH];
	logic [SEEN_W-1:0]             seen_q;
	logic                          flag_q;
	psbd_pkg::token_t              tok_q;

	logic                          rec;
	logic                          hit;
	logic                          claim;
	logic                          clr;
	logic [psbd_pkg::TIME_W:0]     diff;
	logic                          in_win;
	logic                          fire;
	psbd_pkg::token_t              tok_nxt;

	// used entries always form a prefix, so the first free cell reached by an
	// unmatched record means no match exists further down
	always_comb begin
		clr    = tok_in.valid && (tok_in.func == psbd_pkg::FUNC_CLEAR);
		rec    = tok_in.valid && (tok_in.func == psbd_pkg::FUNC_RECORD) && !tok_in.done;
		hit    = rec && used_q && (src_q == tok_in.src);
		claim  = rec && !used_q;
		// 33-bit difference; borrow means time went backwards
		diff   = {1'b0, tok_in.tstamp} - {1'b0, hist_q[hidx]};
		in_win = diff[psbd_pkg::TIME_W] ||
			(diff[psbd_pkg::TIME_W-1:0] < {{(psbd_pkg::TIME_W-psbd_pkg::SPAN_W){1'b0}}, span_lim});
		fire   = hit && (seen_q >= thr) && in_win && !flag_q;

		tok_nxt       = tok_in;
		tok_nxt.done  = tok_in.done | hit | claim;
		tok_nxt.burst = tok_in.burst | fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			seen_q <= '0;
			flag_q <= 1'b0;
			tok_q  <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
			if (clr) begin
				used_q <= 1'b0;
				seen_q <= '0;
				flag_q <= 1'b0;
			end else if (claim) begin
				used_q <= 1'b1;
				seen_q <= SEEN_W'(1);
				flag_q <= 1'b0;
			end else if (hit) begin
				if (seen_q < SEEN_MAX) begin
					seen_q <= seen_q + 1'b1;
				end
				flag_q <= flag_q | fire;
			end
		end
	end

	// payload: tag and history shift line
	always_ff @(posedge clk) begin
		if (adv && (hit || claim)) begin
			hist_q[0] <= tok_in.tstamp;
			for (int k = 1; k < HIST_DEPTH; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
		if (adv && claim) begin
			src_q <= tok_in.src;
		end
	end

	assign tok_out = tok_q;
	assign used    = used_q;

endmodule
